// ----- rtl/sts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared constants, operation codes and the result record of the sorted
// table search block.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int STS_DEPTH     = 256;
   localparam int STS_KEY_WIDTH = 32;

   // Field widths of the stream payloads.
   localparam int OPCODE_W  = 2;
   localparam int POS_W     = 9;
   localparam int KEY_W     = 32;
   localparam int IDX_W     = 9;
   localparam int CNT_OUT_W = 9;

   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = OPCODE_W;
   localparam int RSP_TDATA_W = 24;

   localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

   // One result record, result_index in the lowest bits.
   typedef struct packed {
      logic                        error;
      logic [CNT_OUT_W-1:0]        count;
      logic                        found;
      logic signed [IDX_W-1:0]     result_index;
   } rsp_fields_type;

endpackage
`default_nettype wire

// ----- rtl/sts_key_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_key_ram
// Key storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sts_key_ram #(
   parameter int DEPTH     = 256,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [KEY_WIDTH-1:0]       wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [KEY_WIDTH-1:0]       rd_data
);

   logic [KEY_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sts_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ctrl
// Operation sequencer: binary search probes, shift loops for insert and
// remove, fill count, compare mode register and the result register.
// ----------------------------------------------------------------------------
module sts_ctrl #(
   parameter int DEPTH     = 256,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic                             csr_wr_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [sts_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic [sts_pkg::POS_W-1:0]        req_position,
   input  wire logic [sts_pkg::KEY_W-1:0]        req_key,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output sts_pkg::rsp_fields_type               rsp_fields,
   output logic                                  ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]              ram_wr_addr,
   output logic [KEY_WIDTH-1:0]                  ram_wr_data,
   output logic                                  ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]              ram_rd_addr,
   input  wire logic [KEY_WIDTH-1:0]             ram_rd_data
);

   import sts_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_BIN_RD = 4'd1;
   localparam logic [3:0] S_BIN_EV = 4'd2;
   localparam logic [3:0] S_LO_EV  = 4'd3;
   localparam logic [3:0] S_HI_EV  = 4'd4;
   localparam logic [3:0] S_INS_RD = 4'd5;
   localparam logic [3:0] S_INS_MV = 4'd6;
   localparam logic [3:0] S_INS_WR = 4'd7;
   localparam logic [3:0] S_RM_RD  = 4'd8;
   localparam logic [3:0] S_RM_MV  = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;

   logic [3:0]           state_ff,      state_in;
   logic                 key_signed_ff, key_signed_in;
   logic [CNT_W-1:0]     count_ff,      count_in;
   logic [KEY_WIDTH-1:0] key_ff,        key_in;
   logic [ADDR_W-1:0]    pos_ff,        pos_in;
   logic [ADDR_W-1:0]    lo_ff,         lo_in;
   logic [ADDR_W-1:0]    hi_ff,         hi_in;
   logic [ADDR_W-1:0]    rptr_ff,       rptr_in;
   logic [IDX_W-1:0]     res_idx_ff,    res_idx_in;
   logic                 res_found_ff,  res_found_in;
   logic                 res_err_ff,    res_err_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   rsp_fields_type       rsp_fields_ff, rsp_fields_in;

   logic [ADDR_W:0]      mid_sum;
   logic [ADDR_W-1:0]    mid;
   logic                 probe_more;
   logic [KEY_WIDTH-1:0] flip;
   logic                 rd_ge;
   logic                 rd_eq;
   logic [CMP_W-1:0]     pos_w;
   logic [CMP_W-1:0]     cnt_w;
   logic                 req_fire;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_fields = rsp_fields_ff;

   // Probe point rounds up, as in the search loop.
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff} + (ADDR_W + 1)'(1);
   assign mid        = mid_sum[ADDR_W:1];
   assign probe_more = (({1'b0, lo_ff} + (ADDR_W + 1)'(1)) < {1'b0, hi_ff});

   // Signed compare is an unsigned compare with the sign bits inverted.
   assign flip  = key_signed_ff ? SIGN_BIT : '0;
   assign rd_ge = ((ram_rd_data ^ flip) >= (key_ff ^ flip));
   assign rd_eq = (ram_rd_data == key_ff);

   assign pos_w = CMP_W'(req_position);
   assign cnt_w = CMP_W'(count_ff);

   always_comb begin
      state_in      = state_ff;
      key_signed_in = csr_wr_en ? csr_wr_data : key_signed_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rptr_in       = rptr_ff;
      res_idx_in    = res_idx_ff;
      res_found_in  = res_found_ff;
      res_err_in    = res_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_fields_in = rsp_fields_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff;
      ram_wr_data   = key_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in       = KEY_WIDTH'(req_key);
               pos_in       = ADDR_W'(req_position);
               res_idx_in   = '0;
               res_found_in = 1'b0;
               res_err_in   = 1'b0;
               unique case (req_opcode)
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        res_idx_in = '1;
                        state_in   = S_FIN;
                     end else begin
                        lo_in    = '0;
                        hi_in    = ADDR_W'(count_ff - CNT_W'(1));
                        state_in = S_BIN_RD;
                     end
                  end
                  OP_INSERT: begin
                     if (pos_w > cnt_w || cnt_w >= CMP_W'(DEPTH)) begin
                        res_err_in = 1'b1;
                        state_in   = S_FIN;
                     end else if (pos_w == cnt_w) begin
                        state_in = S_INS_WR;
                     end else begin
                        rptr_in  = ADDR_W'(count_ff - CNT_W'(1));
                        state_in = S_INS_RD;
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_w >= cnt_w) begin
                        res_err_in = 1'b1;
                        state_in   = S_FIN;
                     end else if (pos_w + CMP_W'(1) == cnt_w) begin
                        count_in = count_ff - CNT_W'(1);
                        state_in = S_FIN;
                     end else begin
                        rptr_in  = ADDR_W'(pos_w + CMP_W'(1));
                        state_in = S_RM_RD;
                     end
                  end
                  default: begin
                     res_err_in = 1'b1;
                     state_in   = S_FIN;
                  end
               endcase
            end
         end
         S_BIN_RD: begin
            ram_rd_en = 1'b1;
            if (probe_more) begin
               ram_rd_addr = mid;
               state_in    = S_BIN_EV;
            end else begin
               ram_rd_addr = lo_ff;
               state_in    = S_LO_EV;
            end
         end
         S_BIN_EV: begin
            if (rd_ge) begin
               hi_in = mid;
            end else begin
               lo_in = mid;
            end
            state_in = S_BIN_RD;
         end
         S_LO_EV: begin
            if (rd_eq) begin
               res_idx_in   = IDX_W'(lo_ff);
               res_found_in = 1'b1;
               state_in     = S_FIN;
            end else if (rd_ge) begin
               res_idx_in = '1;
               state_in   = S_FIN;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = hi_ff;
               state_in    = S_HI_EV;
            end
         end
         S_HI_EV: begin
            // The searched key at or above the upper entry selects it.
            if (!(rd_ge && !rd_eq)) begin
               res_idx_in   = IDX_W'(hi_ff);
               res_found_in = rd_eq;
            end else begin
               res_idx_in = IDX_W'(lo_ff);
            end
            state_in = S_FIN;
         end
         S_INS_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rptr_ff;
            state_in    = S_INS_MV;
         end
         S_INS_MV: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rptr_ff + ADDR_W'(1);
            ram_wr_data = ram_rd_data;
            if (rptr_ff == pos_ff) begin
               state_in = S_INS_WR;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rptr_ff - ADDR_W'(1);
               rptr_in     = rptr_ff - ADDR_W'(1);
            end
         end
         S_INS_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = key_ff;
            count_in    = count_ff + CNT_W'(1);
            state_in    = S_FIN;
         end
         S_RM_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rptr_ff;
            state_in    = S_RM_MV;
         end
         S_RM_MV: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rptr_ff - ADDR_W'(1);
            ram_wr_data = ram_rd_data;
            if (CNT_W'(rptr_ff) + CNT_W'(1) == count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FIN;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rptr_ff + ADDR_W'(1);
               rptr_in     = rptr_ff + ADDR_W'(1);
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_fields_in.result_index = res_idx_ff;
               rsp_fields_in.found        = res_found_ff;
               rsp_fields_in.count        = CNT_OUT_W'(count_ff);
               rsp_fields_in.error        = res_err_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         key_signed_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key_signed_ff <= key_signed_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rptr_ff       <= rptr_in;
      res_idx_ff    <= res_idx_in;
      res_found_ff  <= res_found_in;
      res_err_ff    <= res_err_in;
      rsp_fields_ff <= rsp_fields_in;
   end

endmodule
`default_nettype wire

// ----- rtl/sorted_table_search_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_search_top
// Sorted key table with binary search, positional insert and remove.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time, and a new one is taken while
// the previous result still waits in the output register. All keys sit in one
// single-port-read, single-port-write memory with registered read data, and
// that memory port sets the timing. A search alternates a probe read with its
// evaluation, then checks the lower and, if needed, the upper remaining entry;
// on an empty table it goes straight to the result. An insert moves the entries
// from the end down to the position up by one, then writes the key, or writes
// it directly when it appends; a remove moves the entries above the position
// down by one, or only drops the count when it removes the last entry; both
// move one entry per cycle. An error or an unknown opcode goes straight to the
// result. req_tready returns together with the result. key_signed selects
// two's-complement or unsigned key compare and is written through
// csr_wr_en.
module sorted_table_search_top #(
   parameter int DEPTH     = sts_pkg::STS_DEPTH,
   parameter int KEY_WIDTH = sts_pkg::STS_KEY_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic                               csr_wr_data,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // position [8:0], key [40:9], zero fill above
   input  wire logic [sts_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // opcode [1:0]
   input  wire logic [sts_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // result_index [8:0], found [9], count [18:10], error [19], zero fill above
   output logic [sts_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);

   import sts_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic [POS_W-1:0]     req_position;
   logic [KEY_W-1:0]     req_key;
   rsp_fields_type       rsp_fields;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [KEY_WIDTH-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [KEY_WIDTH-1:0] ram_rd_data;

   assign req_position = req_tdata[POS_W-1:0];
   assign req_key      = req_tdata[POS_W+KEY_W-1:POS_W];
   assign rsp_tdata    = RSP_TDATA_W'(rsp_fields);

   sts_ctrl #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_opcode   (req_tuser),
      .req_position (req_position),
      .req_key      (req_key),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_fields   (rsp_fields),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   sts_key_ram #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire

// ----- rtl/sts_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks of the sorted table search block, bound to its top level.
// ----------------------------------------------------------------------------
module sts_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [sts_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic [sts_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [sts_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   import sts_pkg::*;

   logic                 in_fire;
   logic                 out_fire;
   logic [1:0]           pending_ff,    pending_in;
   logic [CNT_OUT_W-1:0] prev_count_ff, prev_count_in;
   rsp_fields_type       rsp_view;

   assign in_fire  = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;
   assign rsp_view = rsp_fields_type'(rsp_tdata[$bits(rsp_fields_type)-1:0]);

   // Transactions accepted whose results have not yet been taken.
   always_comb begin
      pending_in    = pending_ff + 2'(in_fire) - 2'(out_fire);
      prev_count_in = out_fire ? rsp_view.count : prev_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         prev_count_ff <= '0;
      end else begin
         pending_ff    <= pending_in;
         prev_count_ff <= prev_count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result offered without an accepted transaction");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more transactions in flight than the block can hold");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      out_fire |-> (rsp_view.error ? (rsp_view.count == prev_count_ff)
                    : (rsp_view.count == prev_count_ff
                       || rsp_view.count == prev_count_ff + CNT_OUT_W'(1)
                       || rsp_view.count == prev_count_ff - CNT_OUT_W'(1))))
      else $error("fill count moved by more than one entry");

   // The request payload is checked here only for stability while stalled.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid
         && $stable(req_tdata) && $stable(req_tuser))
      else $error("request changed or dropped while stalled");

endmodule

bind sorted_table_search_top sts_checker u_sts_checker (.*);
`default_nettype wire

// ----- tb/tb_sorted_table_search_top.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_table_search_top
// Self-checking bench for the sorted key table. A queue of requests feeds a
// clocked driver, and a clocked monitor compares every response with the
// output of a local table model that is updated on each accepted request.
// Directed corner cases run first, then a full-table pass. Random phases
// follow under both key compare modes, with random idle cycles on both
// streams and one long response stall.
// ----------------------------------------------------------------------------
module tb_sorted_table_search_top;
   import sts_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int LONG_HOLD   = 800;
   localparam int DRAIN_WAIT  = 300;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [POS_W-1:0]    position;
      logic [KEY_W-1:0]    key;
   } table_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Table model, updated at the edge of each request transaction.
   logic [KEY_W-1:0] key_tbl [STS_DEPTH] = '{default: '0};
   int unsigned tbl_count = 0;
   bit cmp_signed = 1'b0;
   rsp_fields_type rsp_expected [$];

   // Planned table contents, followed while requests are queued.
   logic [KEY_W-1:0] plan_keys [$];
   bit plan_signed = 1'b0;
   table_req_type req_pending [$];

   table_req_type req_now;
   rsp_fields_type rsp_got, rsp_want;
   bit quiet = 1'b0;
   int send_wait = 0;
   int recv_wait = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int fail_count = 0;
   int rsp_seen = 0;
   int cycles = 0;

   sorted_table_search_top uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int key_order(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b, bit sgn);
      if (sgn) begin
         a[KEY_W-1] = ~a[KEY_W-1];
         b[KEY_W-1] = ~b[KEY_W-1];
      end
      if (a == b) return 0;
      return (a > b) ? 1 : -1;
   endfunction

   // Binary search over the model table with the same probe order as the block,
   // so that an unsorted table gives the same answer too.
   function automatic int table_lookup(logic [KEY_W-1:0] k);
      int unsigned lo, hi, mid;
      int c;
      if (tbl_count == 0) return -1;
      lo = 0;
      hi = tbl_count - 1;
      mid = (lo + hi + 1) / 2;
      while (lo + 1 < hi) begin
         if (key_order(key_tbl[mid], k, cmp_signed) >= 0) hi = mid;
         else lo = mid;
         mid = (lo + hi + 1) / 2;
      end
      c = key_order(key_tbl[lo], k, cmp_signed);
      if (c < 0) return (key_order(k, key_tbl[hi], cmp_signed) >= 0) ? int'(hi) : int'(lo);
      if (c == 0) return int'(lo);
      return -1;
   endfunction

   task automatic table_step(table_req_type rq);
      rsp_fields_type want;
      int idx;
      want = '0;
      case (rq.opcode)
         OP_SEARCH: begin
            idx = table_lookup(rq.key);
            want.result_index = idx[IDX_W-1:0];
            if (idx >= 0 && key_order(key_tbl[idx], rq.key, cmp_signed) == 0)
               want.found = 1'b1;
         end
         OP_INSERT: begin
            if (rq.position > tbl_count || tbl_count >= STS_DEPTH) begin
               want.error = 1'b1;
            end else begin
               for (int i = tbl_count; i > rq.position; i--) key_tbl[i] = key_tbl[i-1];
               key_tbl[rq.position] = rq.key;
               tbl_count++;
            end
         end
         OP_REMOVE: begin
            if (rq.position >= tbl_count) begin
               want.error = 1'b1;
            end else begin
               for (int i = rq.position + 1; i < tbl_count; i++) key_tbl[i-1] = key_tbl[i];
               tbl_count--;
            end
         end
         default: want.error = 1'b1;
      endcase
      want.count = tbl_count[CNT_OUT_W-1:0];
      rsp_expected.push_back(want);
   endtask

   task automatic report_failure(string msg);
      fail_count++;
      if (fail_count <= 40) $display("%s", msg);
   endtask

   function automatic int idle_draw();
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (csr_wr_en) cmp_signed = csr_wr_data;
         if (req_tvalid && req_tready) table_step(req_now);
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (req_pending.size() > 0) begin
               req_now = req_pending.pop_front();
               req_tdata <= {7'b0, req_now.key, req_now.position};
               req_tuser <= req_now.opcode;
               req_tvalid <= 1'b1;
               send_wait = idle_draw();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and ready generator.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_got = rsp_tdata[$bits(rsp_fields_type)-1:0];
            if (rsp_expected.size() == 0) begin
               report_failure($sformatf("response %0d arrived with nothing expected", rsp_seen));
            end else begin
               rsp_want = rsp_expected.pop_front();
               if (rsp_got.result_index !== rsp_want.result_index
                   || rsp_got.found !== rsp_want.found
                   || rsp_got.count !== rsp_want.count
                   || rsp_got.error !== rsp_want.error)
                  report_failure($sformatf(
                     {"response %0d: got idx %0d found %0d count %0d err %0d, ",
                      "want %0d %0d %0d %0d"},
                     rsp_seen, rsp_got.result_index, rsp_got.found, rsp_got.count,
                     rsp_got.error, rsp_want.result_index, rsp_want.found, rsp_want.count,
                     rsp_want.error));
            end
            rsp_seen++;
            recv_wait = idle_draw();
         end
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_sorted_table_search_top: FAIL");
         $finish;
      end
   end

   task automatic queue_op(logic [OPCODE_W-1:0] op, int pos, logic [KEY_W-1:0] k);
      table_req_type rq;
      rq.opcode = op;
      rq.position = pos[POS_W-1:0];
      rq.key = k;
      req_pending.push_back(rq);
      if (op == OP_INSERT && pos <= plan_keys.size() && plan_keys.size() < STS_DEPTH)
         plan_keys.insert(pos, k);
      else if (op == OP_REMOVE && pos < plan_keys.size())
         plan_keys.delete(pos);
   endtask

   // Position that keeps the planned table sorted: before or after equal keys.
   function automatic int sorted_slot(logic [KEY_W-1:0] k, bit after_equal);
      int i;
      i = 0;
      while (i < plan_keys.size()
             && key_order(plan_keys[i], k, plan_signed) < (after_equal ? 1 : 0)) i++;
      return i;
   endfunction

   function automatic logic [KEY_W-1:0] draw_key();
      case ($urandom_range(0, 5))
         0, 1: return $urandom();
         2, 3: return $urandom_range(0, 64) - 32;
         4: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                   + $urandom_range(0, 4) - 2;
         default: return {($urandom_range(0, 1) ? 16'hFFFF : 16'h0000), 16'($urandom())};
      endcase
   endfunction

   task automatic queue_random_op(int target);
      int r, n, ins_cut;
      logic [KEY_W-1:0] k;
      n = plan_keys.size();
      ins_cut = (n < target) ? 75 : 57;
      r = $urandom_range(0, 99);
      k = draw_key();
      if (r < 40) begin
         if (n > 0 && $urandom_range(0, 2) != 0)
            k = plan_keys[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
         queue_op(OP_SEARCH, $urandom_range(0, 511), k);
      end else if (r < ins_cut) begin
         r = $urandom_range(0, 19);
         if (r < 16) queue_op(OP_INSERT, sorted_slot(k, r[0]), k);
         else if (r < 18) queue_op(OP_INSERT, $urandom_range(0, n), k);
         else queue_op(OP_INSERT, $urandom_range(0, 511), k);
      end else if (r < 95) begin
         if (n > 0 && $urandom_range(0, 9) != 0) queue_op(OP_REMOVE, $urandom_range(0, n - 1), k);
         else queue_op(OP_REMOVE, $urandom_range(0, 511), k);
      end else begin
         queue_op(OP_UNKNOWN, $urandom_range(0, 511), k);
      end
   endtask

   // Waits until the block has nothing in flight.
   task automatic settle();
      do @(negedge clock);
      while (req_pending.size() != 0 || req_tvalid || rsp_expected.size() != 0);
   endtask

   task automatic write_cfg(bit v);
      settle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      plan_signed = v;
      @(negedge clock);
   endtask

   task automatic empty_table();
      while (plan_keys.size() > 0)
         queue_op(OP_REMOVE, $urandom_range(0, plan_keys.size() - 1), draw_key());
   endtask

   initial begin
      logic [KEY_W-1:0] k;
      int target;
      bit sgn;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases with unsigned compare.
      write_cfg(1'b0);
      queue_op(OP_SEARCH, 0, 32'h0);
      queue_op(OP_REMOVE, 0, 32'h0);
      queue_op(OP_INSERT, 1, 32'h5);
      queue_op(OP_UNKNOWN, 511, 32'hFFFF_FFFF);
      queue_op(OP_INSERT, 0, 32'h8000_0000);
      queue_op(OP_INSERT, 1, 32'hFFFF_FFFF);
      queue_op(OP_INSERT, 0, 32'h0000_0000);
      queue_op(OP_INSERT, 1, 32'h7FFF_FFFF);
      queue_op(OP_INSERT, 2, 32'h7FFF_FFFF);
      queue_op(OP_SEARCH, 0, 32'h0000_0000);
      queue_op(OP_SEARCH, 511, 32'hFFFF_FFFF);
      queue_op(OP_SEARCH, 3, 32'h7FFF_FFFF);
      queue_op(OP_SEARCH, 0, 32'h7FFF_FFFE);
      queue_op(OP_SEARCH, 0, 32'h8000_0001);
      queue_op(OP_REMOVE, 511, 32'h0);
      queue_op(OP_INSERT, 511, 32'h1);
      queue_op(OP_REMOVE, 4, 32'h0);
      queue_op(OP_REMOVE, 0, 32'h0);
      queue_op(OP_SEARCH, 0, 32'h0000_0000);
      // The same entries seen as signed keys are no longer in order.
      write_cfg(1'b1);
      queue_op(OP_SEARCH, 0, 32'hFFFF_FFFF);
      queue_op(OP_SEARCH, 0, 32'h8000_0000);
      queue_op(OP_SEARCH, 0, 32'h0000_0000);
      queue_op(OP_SEARCH, 0, 32'h7FFF_FFFF);

      // Fill the table completely, try inserts into the full table, then shrink.
      settle();
      empty_table();
      while (plan_keys.size() < STS_DEPTH) begin
         k = draw_key();
         queue_op(OP_INSERT, sorted_slot(k, $urandom_range(0, 1)), k);
      end
      queue_op(OP_INSERT, STS_DEPTH, draw_key());
      queue_op(OP_INSERT, 0, draw_key());
      queue_op(OP_INSERT, $urandom_range(0, 511), draw_key());
      repeat (20) queue_random_op(STS_DEPTH);
      while (plan_keys.size() > 100)
         queue_op(OP_REMOVE, $urandom_range(0, plan_keys.size() - 1), draw_key());

      // Random phases; the sender drains between them so the register can change.
      for (int ph = 0; ph < 8; ph++) begin
         sgn = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
         write_cfg(sgn);
         quiet = (ph % 4 == 1) || (ph == 2);
         // A long response stall while requests keep coming fills the block.
         if (ph == 2) hold_asks++;
         target = (ph % 3 == 0) ? $urandom_range(2, 12) : $urandom_range(20, 150);
         if (ph % 2 == 0) empty_table();
         repeat (160) queue_random_op(target);
      end

      settle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_sorted_table_search_top: PASS");
      end else begin
         $display("tb_sorted_table_search_top: FAIL");
      end
      $finish;
   end

endmodule
